// ===== src/double_ended_queue_macros.svh =====
// Assertion macros used by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== src/deq_pkg.sv =====
// Package with the field widths, operation codes and status codes of the double-ended queue.
package deq_pkg;

   // Field widths of the request and response channels.
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Default sizing.
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PEEK_FRONT = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_PEEK_BACK  = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

   // Result control passed from the controller to the response register.
   typedef struct packed {
      logic                load;
      logic                use_ram;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                empty;
   } result_ctl_type;

endpackage

// ===== src/deq_req_if.sv =====
// Request channel interface of the double-ended queue.
interface deq_req_if;
   logic                        valid;
   logic                        ready;
   logic [deq_pkg::FUNC_W-1:0]  func;
   logic [deq_pkg::VALUE_W-1:0] push_value;

   modport source (output valid, output func, output push_value, input ready);
   modport sink (input valid, input func, input push_value, output ready);
endinterface

// ===== src/deq_rsp_if.sv =====
// Response channel interface of the double-ended queue.
interface deq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [deq_pkg::VALUE_W-1:0]  read_value;
   logic [deq_pkg::COUNT_W-1:0]  element_count;
   logic                         is_empty;
   logic [deq_pkg::STATUS_W-1:0] status;

   modport source (output valid, output read_value, output element_count, output is_empty,
                   output status, input ready);
   modport sink (input valid, input read_value, input element_count, input is_empty,
                 input status, output ready);
endinterface

// ===== src/deq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module deq_ram #(
   parameter int WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/deq_ctrl.sv =====
// Pointer, count and sequencing logic of the double-ended queue.
module deq_ctrl #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [deq_pkg::FUNC_W-1:0]   req_func,
   input  logic [deq_pkg::VALUE_W-1:0]  req_value,
   output logic                         req_ready,
   input  logic                         out_free,
   output logic                         ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]     ram_wr_addr,
   output logic [DATA_WIDTH-1:0]        ram_wr_data,
   output logic                         ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]     ram_rd_addr,
   output deq_pkg::result_ctl_type      result_ctl
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                          state_ff, state_in;
   logic [PTR_W-1:0]              front_ff, front_in;
   logic [PTR_W-1:0]              back_ff, back_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   deq_pkg::result_ctl_type       meta_ff, meta_in;

   logic                          accept;
   logic                          full;
   logic                          empty;
   logic [PTR_W-1:0]              front_inc, front_dec, back_inc, back_dec;
   logic [deq_pkg::STATUS_W-1:0]  status_now;
   logic                          read_now;

   // The queue takes a request only between operations and when the response register can
   // take a result in the same cycle.
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // Ring neighbours of both pointers.
   assign front_inc = (front_ff == PTR_LAST) ? '0 : front_ff + PTR_W'(1);
   assign front_dec = (front_ff == '0) ? PTR_LAST : front_ff - PTR_W'(1);
   assign back_inc  = (back_ff == PTR_LAST) ? '0 : back_ff + PTR_W'(1);
   assign back_dec  = (back_ff == '0) ? PTR_LAST : back_ff - PTR_W'(1);

   assign ram_wr_data = DATA_WIDTH'(req_value);

   // Decode the operation into the memory access and the pointer and count updates.
   always_comb begin
      front_in    = front_ff;
      back_in     = back_ff;
      count_in    = count_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = back_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = front_ff;
      status_now  = deq_pkg::STATUS_OK;
      read_now    = 1'b0;
      case (req_func)
         deq_pkg::FUNC_PUSH_FRONT: begin
            if (full) begin
               status_now = deq_pkg::STATUS_OVERFLOW;
            end else begin
               ram_wr_en   = accept;
               ram_wr_addr = front_dec;
               front_in    = front_dec;
               count_in    = count_ff + CNT_W'(1);
            end
         end
         deq_pkg::FUNC_PUSH_BACK: begin
            if (full) begin
               status_now = deq_pkg::STATUS_OVERFLOW;
            end else begin
               ram_wr_en   = accept;
               ram_wr_addr = back_ff;
               back_in     = back_inc;
               count_in    = count_ff + CNT_W'(1);
            end
         end
         deq_pkg::FUNC_POP_FRONT: begin
            if (empty) begin
               status_now = deq_pkg::STATUS_UNDERFLOW;
            end else begin
               read_now    = 1'b1;
               ram_rd_addr = front_ff;
               front_in    = front_inc;
               count_in    = count_ff - CNT_W'(1);
            end
         end
         deq_pkg::FUNC_POP_BACK: begin
            if (empty) begin
               status_now = deq_pkg::STATUS_UNDERFLOW;
            end else begin
               read_now    = 1'b1;
               ram_rd_addr = back_dec;
               back_in     = back_dec;
               count_in    = count_ff - CNT_W'(1);
            end
         end
         deq_pkg::FUNC_PEEK_FRONT: begin
            if (empty) begin
               status_now = deq_pkg::STATUS_UNDERFLOW;
            end else begin
               read_now    = 1'b1;
               ram_rd_addr = front_ff;
            end
         end
         deq_pkg::FUNC_PEEK_BACK: begin
            if (empty) begin
               status_now = deq_pkg::STATUS_UNDERFLOW;
            end else begin
               read_now    = 1'b1;
               ram_rd_addr = back_dec;
            end
         end
         default: begin
            // Unused codes leave the queue untouched and report success.
            status_now = deq_pkg::STATUS_OK;
         end
      endcase
      ram_rd_en = accept && read_now;
   end

   // Result fields of the current request, before any memory data is known.
   always_comb begin
      meta_in.load    = 1'b1;
      meta_in.use_ram = read_now;
      meta_in.status  = status_now;
      meta_in.count   = deq_pkg::COUNT_W'(count_in);
      meta_in.empty   = (count_in == '0);
   end

   // Results without memory data leave at once; reads leave in the following cycle with the data.
   always_comb begin
      if (state_ff == ST_READ) begin
         result_ctl = meta_ff;
      end else begin
         result_ctl      = meta_in;
         result_ctl.load = accept && !read_now;
      end
   end

   // Sequencer: a read parks the result fields until the memory answers.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && read_now) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            front_ff <= front_in;
            back_ff  <= back_in;
            count_ff <= count_in;
         end
      end
   end

   // Parked result fields need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta_in;
      end
   end

endmodule

// ===== src/double_ended_queue.sv =====
// Double-ended queue: push and pop at both ends of a ring held in a single RAM, one response
// per request. A push, an error or an unused code loads its response straight into the
// output register; a pop or peek first passes the element through the RAM's registered read
// port, and no request is taken in the cycle the read data returns. Each response waits in an
// output register, and a new request is accepted in the cycle that register is drained. Pops
// and peeks on an empty queue report underflow; pushes onto a full queue report overflow and
// drop the element; neither changes the queue. Element count wider than the response field is
// reported modulo its width.
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req_if,
   deq_rsp_if.source  rsp_if
);

   localparam int PTR_W = $clog2(DEPTH);

   logic                         out_free;
   logic                         ram_wr_en;
   logic [PTR_W-1:0]             ram_wr_addr;
   logic [DATA_WIDTH-1:0]        ram_wr_data;
   logic                         ram_rd_en;
   logic [PTR_W-1:0]             ram_rd_addr;
   logic [DATA_WIDTH-1:0]        ram_rd_data;
   deq_pkg::result_ctl_type      result_ctl;

   logic                         rsp_valid_ff;
   logic [deq_pkg::VALUE_W-1:0]  read_value_ff;
   logic [deq_pkg::COUNT_W-1:0]  count_ff;
   logic                         empty_ff;
   logic [deq_pkg::STATUS_W-1:0] status_ff;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Pointer and count control.
   deq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_func    (req_if.func),
      .req_value   (req_if.push_value),
      .req_ready   (req_if.ready),
      .out_free    (out_free),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .result_ctl  (result_ctl)
   );

   // Element store.
   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (result_ctl.load) begin
         read_value_ff <= result_ctl.use_ram ? deq_pkg::VALUE_W'(ram_rd_data) : '0;
         count_ff      <= result_ctl.count;
         empty_ff      <= result_ctl.empty;
         status_ff     <= result_ctl.status;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.read_value    = read_value_ff;
   assign rsp_if.element_count = count_ff;
   assign rsp_if.is_empty      = empty_ff;
   assign rsp_if.status        = status_ff;

   // A new result must never overwrite one that is still waiting.
   `DEQ_ASSERT_SAME(a_no_overwrite, clock, reset, result_ctl.load, out_free)

   // While memory data is returning, no request is taken.
   `DEQ_ASSERT_SAME(a_read_blocks_req, clock, reset, result_ctl.load && result_ctl.use_ram,
                    !req_if.ready)

   // Error responses never carry an element.
   `DEQ_ASSERT_SAME(a_error_zero, clock, reset,
                    rsp_valid_ff && (status_ff != deq_pkg::STATUS_OK), read_value_ff == '0)

   // A memory read is always followed by the response that carries its data.
   `DEQ_ASSERT_NEXT(a_read_answered, clock, reset, ram_rd_en,
                    result_ctl.load && result_ctl.use_ram)

endmodule
